@@ sv/lmbr_pkg.sv @@
// ----------------------------------------------------------------------------
// lmbr_pkg
// Shared types, header codes and fixed tables of the lock-module responder.
// ----------------------------------------------------------------------------
package lmbr_pkg;

  localparam logic [7:0] ID_ARM   = 8'h11;
  localparam logic [7:0] ID_SHORT = 8'hC1;
  localparam logic [7:0] ID_LONG  = 8'h37;
  localparam logic [7:0] ID_MODE  = 8'hF5;

  localparam logic [7:0] SEL_BRAKE = 8'h05;
  localparam logic [7:0] SEL_START = 8'h41;

  localparam logic [1:0] MODE_DOOR  = 2'd0;
  localparam logic [1:0] MODE_BRAKE = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [1:0] LED_NONE  = 2'd0;
  localparam logic [1:0] LED_ARM   = 2'd1;
  localparam logic [1:0] LED_START = 2'd2;

  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_SHORT = 4'd2;
  localparam logic [3:0] LEN_LONG  = 4'd8;

  localparam logic [7:0] HIGH_RESET  = 8'h08;
  localparam logic [7:0] LOW_RESET   = 8'h01;
  localparam logic [7:0] HIGH_MODE   = 8'h04;
  localparam logic [7:0] OFFSET_LONG = 8'h04;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;

  typedef logic [5:0][7:0] tail_t;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
  } pair_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] hi;
  } lookup_t;

  localparam pair_t DOOR_TAB [5] = '{
    '{hi: 8'h08, lo: 8'h01}, '{hi: 8'h07, lo: 8'h04}, '{hi: 8'h87, lo: 8'h0A},
    '{hi: 8'h88, lo: 8'h0B}, '{hi: 8'h84, lo: 8'h18}
  };
  localparam pair_t START_TAB [2] = '{
    '{hi: 8'h04, lo: 8'h01}, '{hi: 8'h07, lo: 8'h15}
  };

  localparam tail_t TAIL_DOOR  = {8'h00, 8'hD1, 8'hE1, 8'hF0, 8'h78, 8'hE2};
  localparam tail_t TAIL_START = {8'h00, 8'h62, 8'hD6, 8'hE1, 8'h46, 8'hA4};

  // First matching entry wins; brake mode and the unused code never match.
  function automatic lookup_t mode_lookup(input logic [1:0] mode, input logic [7:0] low);
    lookup_t r;
    r = '0;
    if (mode == MODE_DOOR) begin
      for (int i = 4; i >= 0; i--) begin
        if (DOOR_TAB[i].lo == low) begin
          r.hit = 1'b1;
          r.hi  = DOOR_TAB[i].hi;
        end
      end
    end else if (mode == MODE_START) begin
      for (int i = 1; i >= 0; i--) begin
        if (START_TAB[i].lo == low) begin
          r.hit = 1'b1;
          r.hi  = START_TAB[i].hi;
        end
      end
    end
    return r;
  endfunction

endpackage

@@ sv/lock_module_bus_responder_core.sv @@
// ----------------------------------------------------------------------------
// lock_module_bus_responder_core
// Emulated lock-module bus slave answering frame headers with responses.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one bus header: tdata carries the frame
// identifier and the first received data byte, tuser the checksum-ok flag.
// Every request yields exactly one result on the master stream: tuser carries
// the send flag, tdata the response length, eight response bytes and the LED
// request code.
// The mode, arm flag, counters and payload tail are updated in the cycle a
// request is accepted, and the result is registered, so it appears in the
// cycle after. One request is taken every cycle while results are taken; the
// only limit is the single result register.
// When the receiver stalls, the result register holds its value and the slave
// side stops accepting until the result is taken.
// After reset the block is in door mode, unarmed, with the high counter at
// 0x08, the low counter at 0x01, no offset and an all-zero payload tail.
// ----------------------------------------------------------------------------
module lock_module_bus_responder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] hdr_id, [15:8] rx_first_byte
  input  logic [lmbr_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] rx_ok
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [3:0] resp_len, [11:4] resp_b0, [19:12] resp_b1, ... [67:60] resp_b7,
  // [69:68] led_request, [71:70] zero
  output logic [lmbr_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] send
  output logic                          m_axis_tuser_o
);
  import lmbr_pkg::*;

  logic [1:0] mode_q, mode_d;
  logic       armed_q, armed_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic [7:0] offset_q, offset_d;
  tail_t      tail_q, tail_d;

  logic                valid_q;
  logic [OutDataW-1:0] data_q, data_d;
  logic                send_q, send_d;

  logic       accept;
  logic [7:0] hdr_id;
  logic [7:0] first_byte;
  logic       rx_ok;
  lookup_t    lk;
  logic [3:0] len;
  logic [7:0] b0;
  logic [7:0] b1;
  tail_t      bytes;
  logic [1:0] led;

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign hdr_id          = s_axis_tdata_i[7:0];
  assign first_byte      = s_axis_tdata_i[15:8];
  assign rx_ok           = s_axis_tuser_i;
  assign lk              = mode_lookup(mode_q, low_q);

  always_comb begin
    mode_d   = mode_q;
    armed_d  = armed_q;
    high_d   = high_q;
    low_d    = low_q;
    offset_d = offset_q;
    tail_d   = tail_q;
    send_d   = 1'b0;
    len      = LEN_NONE;
    b0       = '0;
    b1       = '0;
    bytes    = '0;
    led      = LED_NONE;
    case (hdr_id)
      ID_ARM: begin
        if (rx_ok && mode_q == MODE_DOOR && !armed_q) begin
          high_d   = HIGH_RESET;
          low_d    = LOW_RESET;
          offset_d = '0;
          armed_d  = 1'b1;
          led      = LED_ARM;
        end
      end
      ID_MODE: begin
        if (rx_ok && (first_byte == SEL_BRAKE || first_byte == SEL_START)) begin
          high_d   = HIGH_MODE;
          low_d    = LOW_RESET;
          offset_d = '0;
          armed_d  = 1'b0;
          if (first_byte == SEL_BRAKE) begin
            mode_d = MODE_BRAKE;
          end else begin
            mode_d = MODE_START;
            led    = LED_START;
          end
        end
      end
      ID_SHORT: begin
        if (lk.hit) begin
          high_d   = lk.hi;
          offset_d = '0;
        end
        send_d = 1'b1;
        len    = LEN_SHORT;
        b0     = high_d + offset_d;
        b1     = low_q;
        low_d  = low_q + 8'd1;
      end
      ID_LONG: begin
        if (mode_q == MODE_DOOR) begin
          if (lk.hit) begin
            high_d   = lk.hi;
            offset_d = '0;
          end
          tail_d = TAIL_DOOR;
        end else if (mode_q == MODE_START) begin
          high_d   = HIGH_MODE;
          offset_d = OFFSET_LONG;
          tail_d   = TAIL_START;
        end
        send_d = 1'b1;
        len    = LEN_LONG;
        b0     = high_d;
        b1     = low_q;
        bytes  = tail_d;
        low_d  = low_q + 8'd1;
      end
      default: begin
      end
    endcase
    data_d = {2'b00, led, bytes, b1, b0, len};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DOOR;
      armed_q  <= 1'b0;
      high_q   <= HIGH_RESET;
      low_q    <= LOW_RESET;
      offset_q <= '0;
      tail_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        armed_q  <= armed_d;
        high_q   <= high_d;
        low_q    <= low_d;
        offset_q <= offset_d;
        tail_q   <= tail_d;
        valid_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
      send_q <= send_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = send_q;

endmodule
